>>> hdl/bqkr_pkg.sv
// Shared types and constants for the bounded queue with keyed removal.
// Used by every module of the block; depends on nothing.
package bqkr_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int KEY_W    = 34;
  localparam int SCORE_W  = 8;
  localparam int MEAN_W   = 8;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 2;

  // Stream bus widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  // Mean of three scores: floor(sum / 3) == (sum * 683) >> 11 for sum <= 765
  localparam int SUM_W      = SCORE_W + 2;
  localparam int MEAN_RECIP = 683;
  localparam int MEAN_SHIFT = 11;
  localparam int PROD_W     = 20;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_ENTRY   = 3'd4
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [MEAN_W-1:0]  mean;
  } cmd_t;

endpackage

>>> hdl/bqkr_front.sv
// Front end: accepts input items, drops unused operation codes and
// computes the mean of the three scores. Depends on bqkr_pkg.
module bqkr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: key[33:0], score_one[41:34], score_two[49:42], score_three[57:50]
  input  logic [bqkr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [bqkr_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output bqkr_pkg::cmd_t                    cmd_o
);
  import bqkr_pkg::*;

  logic                 valid_q, valid_d;
  cmd_t                 cmd_q;
  logic                 accept;
  logic                 op_known;
  logic [SUM_W-1:0]     sum;
  logic [PROD_W-1:0]    prod;
  logic [SCORE_W-1:0]   score_one, score_two, score_three;

  assign score_one   = s_axis_tdata[KEY_W +: SCORE_W];
  assign score_two   = s_axis_tdata[KEY_W + SCORE_W +: SCORE_W];
  assign score_three = s_axis_tdata[KEY_W + 2*SCORE_W +: SCORE_W];

  // Take a new item whenever the stage is empty or drains this cycle
  assign s_axis_tready = !valid_q || cmd_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Only the three defined operations go on to the back end
  assign op_known = (s_axis_tuser == OP_APPEND) || (s_axis_tuser == OP_REMOVE) ||
                    (s_axis_tuser == OP_LIST);

  // Divide the score sum by three through a reciprocal multiply
  assign sum  = SUM_W'(score_one) + SUM_W'(score_two) + SUM_W'(score_three);
  assign prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = op_known;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the classified command until the queue takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op   <= op_e'(s_axis_tuser);
      cmd_q.key  <= s_axis_tdata[KEY_W-1:0];
      cmd_q.mean <= prod[MEAN_SHIFT +: MEAN_W];
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hdl/bqkr_fifo.sv
// Short command queue that decouples the front end from the back end.
// Depends on bqkr_pkg for the command type and depth.
module bqkr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  bqkr_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output bqkr_pkg::cmd_t  pop_cmd_o
);
  import bqkr_pkg::*;

  localparam int PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int FCNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t               slots_q [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0]  fill_q;
  logic               do_push, do_pop;

  assign push_ready_o = (fill_q != FCNT_W'(CMD_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slots_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FCNT_W'(1);
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/bqkr_back.sv
// Back end: holds the record store and capacity register, carries out
// append, keyed removal and listing, and registers the results.
// Depends on bqkr_pkg.
module bqkr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bqkr_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  bqkr_pkg::cmd_t                    cmd_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output bqkr_pkg::status_e                 res_status_o,
  output logic [bqkr_pkg::KEY_W-1:0]        res_key_o,
  output logic [bqkr_pkg::MEAN_W-1:0]       res_mean_o,
  output logic                              res_last_o
);
  import bqkr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_LIST   = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     max_entries_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [KEY_W-1:0]     keys_q  [QUEUE_DEPTH];
  logic [MEAN_W-1:0]    means_q [QUEUE_DEPTH];

  logic [CNT_W-1:0]     cap;
  logic                 at_last;
  logic                 hit;
  logic                 out_ready;
  logic                 out_load;
  logic                 do_append;
  logic                 do_shift;
  status_e              res_status;
  logic [KEY_W-1:0]     res_key;
  logic [MEAN_W-1:0]    res_mean;
  logic                 res_last;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [MEAN_W-1:0]    out_mean_q;
  logic                 out_last_q;

  // Capacity in use is the register limited to the store depth
  always_comb begin
    if (int'(max_entries_q) < QUEUE_DEPTH) begin
      cap = CNT_W'(max_entries_q);
    end else begin
      cap = CNT_W'(QUEUE_DEPTH);
    end
  end

  assign at_last   = (CNT_W'(idx_q) == count_q - CNT_W'(1));
  assign hit       = (keys_q[idx_q] == key_q);
  assign out_ready = !out_valid_q || res_ready_i;

  // Sequencer: one step per cycle, only when the result register is free
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    key_d       = key_q;
    cmd_ready_o = 1'b0;
    out_load    = 1'b0;
    do_append   = 1'b0;
    do_shift    = 1'b0;
    res_status  = ST_DONE;
    res_key     = '0;
    res_mean    = '0;
    res_last    = 1'b1;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = out_ready;
        if (cmd_valid_i && out_ready) begin
          case (cmd_i.op)
            OP_APPEND: begin
              out_load = 1'b1;
              if (count_q >= cap) begin
                res_status = ST_FULL;
              end else begin
                do_append = 1'b1;
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_d = S_SEARCH;
                idx_d   = '0;
                key_d   = cmd_i.key;
              end
            end
            OP_LIST: begin
              if (count_q == '0) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_d = S_LIST;
                idx_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (out_ready) begin
          if (hit) begin
            do_shift = 1'b1;
            count_d  = count_q - CNT_W'(1);
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else if (at_last) begin
            out_load   = 1'b1;
            res_status = ST_MISSING;
            state_d    = S_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      S_LIST: begin
        if (out_ready) begin
          out_load   = 1'b1;
          res_status = ST_ENTRY;
          res_key    = keys_q[idx_q];
          res_mean   = means_q[idx_q];
          res_last   = at_last;
          if (at_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      key_q         <= '0;
      max_entries_q <= CFG_W'(16);
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      key_q   <= key_d;
      if (cfg_we_i) begin
        max_entries_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Record store: write at the tail, close the gap above a removed entry
  always_ff @(posedge clk_i) begin
    if (do_append) begin
      keys_q[count_q[IDX_W-1:0]]  <= cmd_i.key;
      means_q[count_q[IDX_W-1:0]] <= cmd_i.mean;
    end
    if (do_shift) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (IDX_W'(j) >= idx_q) begin
          keys_q[j]  <= keys_q[j+1];
          means_q[j] <= means_q[j+1];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_key_q    <= res_key;
      out_mean_q   <= res_mean;
      out_last_q   <= res_last;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_key_o    = out_key_q;
  assign res_mean_o   = out_mean_q;
  assign res_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above store depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
         count_q == $past(count_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (count_q != '0))
    else $error("search or list running on an empty queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_ready)
    else $error("result register overwritten before delivery");
`endif

endmodule

>>> hdl/bounded_queue_keyed_removal.sv
// Top level of the bounded queue with keyed removal: front end, command
// queue and back end. Depends on bqkr_pkg, bqkr_front, bqkr_fifo, bqkr_back.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid / tready         tdata: key, scores; tuser: operation
//   m_axis    out  tvalid / tready         tdata: key, mean; tuser: status; tlast
//   cfg       in   cfg_we_i                cfg_wdata_i: max_entries
//
// Back end: in idle it takes a command and answers an append or an empty remove
// or list directly; a remove compares one entry per step up to the match or the
// tail, a list reads one stored entry per step (each at most 16), set by one store
// read port. An item passes the front register, then the command queue, to reach
// the back end; a result register follows. Reset clears count and handshake
// state, capacity to 16. A stalled m_axis holds every back end step; the front
// keeps accepting until the two-entry command queue and its own register fill.
module bounded_queue_keyed_removal (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: key[33:0], score_one[41:34], score_two[49:42], score_three[57:50]
  input  logic [bqkr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [bqkr_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: entry_key[33:0], entry_mean[41:34], zeros above
  output logic [bqkr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: status[2:0]
  output logic [bqkr_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [bqkr_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import bqkr_pkg::*;

  logic                 fr_valid, fr_ready;
  cmd_t                 fr_cmd;
  logic                 bk_valid, bk_ready;
  cmd_t                 bk_cmd;
  status_e              res_status;
  logic [KEY_W-1:0]     res_key;
  logic [MEAN_W-1:0]    res_mean;

  bqkr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (fr_valid),
    .cmd_ready_i   (fr_ready),
    .cmd_o         (fr_cmd)
  );

  bqkr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_cmd_o    (bk_cmd)
  );

  bqkr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (bk_valid),
    .cmd_ready_o  (bk_ready),
    .cmd_i        (bk_cmd),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_key_o    (res_key),
    .res_mean_o   (res_mean),
    .res_last_o   (m_axis_tlast)
  );

  // Pack the result fields onto the stream bus
  assign m_axis_tdata = {{(OUT_TDATA_W - KEY_W - MEAN_W){1'b0}}, res_mean, res_key};
  assign m_axis_tuser = res_status;

endmodule
